// ----- rtl/core/geomip_fan_index_generator_defines.svh -----
// ----------------------------------------------------------------------------
// geomip fan index generator assertion macros
// shared concurrent assertion forms for the fan index generator
// ----------------------------------------------------------------------------
`ifndef GEOMIP_FAN_INDEX_GENERATOR_DEFINES_SVH
`define GEOMIP_FAN_INDEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define GFI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/gfi_pkg.sv -----
// ----------------------------------------------------------------------------
// gfi package
// widths, register codes and shared types of the fan index generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfi_pkg;

   localparam int COORD_BITS  = 8;
   localparam int LOD_BITS    = 3;
   localparam int GRID_BITS   = 13;
   localparam int PATCH_BITS  = 9;
   localparam int SPAN_BITS   = 9;
   localparam int IDX_BITS    = 21;
   localparam int PROD_BITS   = SPAN_BITS + GRID_BITS;
   localparam int EDGE_BITS   = PATCH_BITS + 2;
   localparam int RING_SIZE   = 8;
   localparam int RING_BITS   = $clog2(RING_SIZE);
   localparam int SIDE_COUNT  = 4;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [GRID_BITS-1:0]  MAX_GRID_WIDTH   = 13'd4096;
   localparam logic [PATCH_BITS-1:0] MAX_PATCH_SIZE   = 9'd257;
   localparam logic [GRID_BITS-1:0]  GRID_WIDTH_RESET = 13'd257;
   localparam logic [PATCH_BITS-1:0] PATCH_SIZE_RESET = 9'd33;

   typedef enum logic [0:0] {
      CSR_GRID_WIDTH = 1'b0,
      CSR_PATCH_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [GRID_BITS-1:0]  grid_width;
      logic [PATCH_BITS-1:0] patch_size;
   } cfg_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]                centre;
      logic [RING_SIZE-1:0][IDX_BITS-1:0] ring;
      logic [SIDE_COUNT-1:0]              merge;
   } fan_type;

endpackage

// ----- rtl/core/gfi_if.sv -----
// ----------------------------------------------------------------------------
// gfi channel interfaces
// fan request channel and triangle result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gfi_req_if import gfi_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] fan_x;
   logic [COORD_BITS-1:0] fan_z;
   logic [LOD_BITS-1:0]   core_lod;
   logic                  left_coarser;
   logic                  right_coarser;
   logic                  top_coarser;
   logic                  bottom_coarser;

   modport source (
      output valid, fan_x, fan_z, core_lod,
             left_coarser, right_coarser, top_coarser, bottom_coarser,
      input  ready
   );
   modport sink (
      input  valid, fan_x, fan_z, core_lod,
             left_coarser, right_coarser, top_coarser, bottom_coarser,
      output ready
   );
endinterface

interface gfi_rsp_if import gfi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [IDX_BITS-1:0] vertex_centre;
   logic [IDX_BITS-1:0] vertex_first;
   logic [IDX_BITS-1:0] vertex_second;
   logic                last_triangle;

   modport source (
      output valid, vertex_centre, vertex_first, vertex_second, last_triangle,
      input  ready
   );
   modport sink (
      input  valid, vertex_centre, vertex_first, vertex_second, last_triangle,
      output ready
   );
endinterface

// ----- rtl/core/gfi_csr.sv -----
// ----------------------------------------------------------------------------
// gfi register file
// apb-style grid width and patch size registers with clamping on write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfi_csr import gfi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   logic [GRID_BITS-1:0]  grid_width_ff, grid_width_in;
   logic [PATCH_BITS-1:0] patch_size_ff, patch_size_in;
   logic [GRID_BITS-1:0]  wr_grid;
   logic [PATCH_BITS-1:0] wr_patch;
   logic                  wr_en;
   csr_index_type         index;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite && pready;
   assign index    = csr_index_type'(paddr[2]);
   assign wr_grid  = pwdata[GRID_BITS-1:0];
   assign wr_patch = pwdata[PATCH_BITS-1:0];

   always_comb begin
      grid_width_in = grid_width_ff;
      patch_size_in = patch_size_ff;
      if (wr_en) begin
         case (index)
            CSR_GRID_WIDTH: begin
               grid_width_in = (wr_grid > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : wr_grid;
            end
            CSR_PATCH_SIZE: begin
               patch_size_in = (wr_patch > MAX_PATCH_SIZE) ? MAX_PATCH_SIZE : wr_patch;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_GRID_WIDTH: prdata = CSR_DATA_BITS'(grid_width_ff);
         CSR_PATCH_SIZE: prdata = CSR_DATA_BITS'(patch_size_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
         patch_size_ff <= PATCH_SIZE_RESET;
      end else begin
         grid_width_ff <= grid_width_in;
         patch_size_ff <= patch_size_in;
      end
   end

   assign cfg.grid_width = grid_width_ff;
   assign cfg.patch_size = patch_size_ff;

endmodule

// ----- rtl/core/gfi_fan_calc.sv -----
// ----------------------------------------------------------------------------
// gfi fan calculator
// registers a fan request and forms its centre, ring indices and edge merges
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "geomip_fan_index_generator_defines.svh"

module gfi_fan_calc import gfi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   gfi_req_if.sink req,
   input  cfg_type cfg,
   output logic    calc_valid,
   input  logic    calc_take,
   output fan_type calc_fan
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [COORD_BITS-1:0] x_ff, z_ff;
   logic [LOD_BITS-1:0]   lod_ff;
   logic                  cl_ff, cr_ff, ct_ff, cb_ff;
   logic                  req_fire;

   logic [SPAN_BITS-1:0]  span, two_span;
   logic [SPAN_BITS-1:0]  r0, r1, r2, c0, c1, c2;
   logic [PROD_BITS-1:0]  p0, p1, p2;
   logic [EDGE_BITS-1:0]  edge_pos;
   logic                  wl, wt, wr, wb;

   assign req.ready = !s1_valid_ff || calc_take;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (calc_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff   <= req.fan_x;
         z_ff   <= req.fan_z;
         lod_ff <= req.core_lod;
         cl_ff  <= req.left_coarser;
         cr_ff  <= req.right_coarser;
         ct_ff  <= req.top_coarser;
         cb_ff  <= req.bottom_coarser;
      end
   end

   // fan square corners and midpoints
   assign span     = SPAN_BITS'(1) << lod_ff;
   assign two_span = span << 1;
   assign r0 = SPAN_BITS'(z_ff);
   assign r1 = SPAN_BITS'(z_ff) + span;
   assign r2 = SPAN_BITS'(z_ff) + two_span;
   assign c0 = SPAN_BITS'(x_ff);
   assign c1 = SPAN_BITS'(x_ff) + span;
   assign c2 = SPAN_BITS'(x_ff) + two_span;

   assign p0 = PROD_BITS'(r0) * PROD_BITS'(cfg.grid_width);
   assign p1 = PROD_BITS'(r1) * PROD_BITS'(cfg.grid_width);
   assign p2 = PROD_BITS'(r2) * PROD_BITS'(cfg.grid_width);

   // far edge position, may be negative
   assign edge_pos = EDGE_BITS'(cfg.patch_size) - EDGE_BITS'(1) - EDGE_BITS'(two_span);

   assign wl = cl_ff && (x_ff == '0);
   assign wb = cb_ff && (z_ff == '0);
   assign wt = ct_ff && !edge_pos[EDGE_BITS-1] && (edge_pos == EDGE_BITS'(z_ff));
   assign wr = cr_ff && !edge_pos[EDGE_BITS-1] && (edge_pos == EDGE_BITS'(x_ff));

   assign calc_valid      = s1_valid_ff;
   assign calc_fan.centre = p1[IDX_BITS-1:0] + IDX_BITS'(c1);
   assign calc_fan.ring[0] = p0[IDX_BITS-1:0] + IDX_BITS'(c0);
   assign calc_fan.ring[1] = p1[IDX_BITS-1:0] + IDX_BITS'(c0);
   assign calc_fan.ring[2] = p2[IDX_BITS-1:0] + IDX_BITS'(c0);
   assign calc_fan.ring[3] = p2[IDX_BITS-1:0] + IDX_BITS'(c1);
   assign calc_fan.ring[4] = p2[IDX_BITS-1:0] + IDX_BITS'(c2);
   assign calc_fan.ring[5] = p1[IDX_BITS-1:0] + IDX_BITS'(c2);
   assign calc_fan.ring[6] = p0[IDX_BITS-1:0] + IDX_BITS'(c2);
   assign calc_fan.ring[7] = p0[IDX_BITS-1:0] + IDX_BITS'(c1);
   assign calc_fan.merge  = {wb, wr, wt, wl};

   // a held request is never dropped
   `GFI_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !calc_take, s1_valid_ff,
      "fan request lost before transfer to sequencer")

endmodule

// ----- rtl/core/gfi_tri_seq.sv -----
// ----------------------------------------------------------------------------
// gfi triangle sequencer
// walks the fan ring one triangle per cycle into the result register while it is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "geomip_fan_index_generator_defines.svh"

module gfi_tri_seq import gfi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      calc_valid,
   output logic      calc_take,
   input  fan_type   calc_fan,
   gfi_rsp_if.source rsp
);

   logic                               fan_valid_ff, fan_valid_in;
   logic [RING_BITS-1:0]               pos_ff, pos_in;
   logic [IDX_BITS-1:0]                centre_ff;
   logic [RING_SIZE-1:0][IDX_BITS-1:0] ring_ff, ring_in;
   logic [SIDE_COUNT-1:0]              merge_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0] centre_out_ff, first_out_ff, second_out_ff;
   logic                last_out_ff;

   logic out_free, emit, merged, last, fan_done;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign emit      = fan_valid_ff && out_free;
   assign merged    = merge_ff[pos_ff[RING_BITS-1:1]] && !pos_ff[0];
   assign last      = (pos_ff == RING_BITS'(RING_SIZE - 1)) ||
                      ((pos_ff == RING_BITS'(RING_SIZE - 2)) && merged);
   assign fan_done  = emit && last;
   assign calc_take = calc_valid && (!fan_valid_ff || fan_done);

   always_comb begin
      for (int i = 0; i < RING_SIZE; i++) begin
         ring_in[i] = merged ? ring_ff[RING_BITS'(i + 2)] : ring_ff[RING_BITS'(i + 1)];
      end
      pos_in       = pos_ff;
      fan_valid_in = fan_valid_ff;
      if (calc_take) begin
         pos_in       = '0;
         fan_valid_in = 1'b1;
      end else if (emit) begin
         pos_in       = last ? '0 : (pos_ff + (merged ? RING_BITS'(2) : RING_BITS'(1)));
         fan_valid_in = !last;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fan_valid_ff <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fan_valid_ff <= fan_valid_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (calc_take) begin
         centre_ff <= calc_fan.centre;
         ring_ff   <= calc_fan.ring;
         merge_ff  <= calc_fan.merge;
      end else if (emit) begin
         ring_ff   <= ring_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         centre_out_ff <= centre_ff;
         first_out_ff  <= ring_ff[0];
         second_out_ff <= merged ? ring_ff[2] : ring_ff[1];
         last_out_ff   <= last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.vertex_centre = centre_out_ff;
   assign rsp.vertex_first  = first_out_ff;
   assign rsp.vertex_second = second_out_ff;
   assign rsp.last_triangle = last_out_ff;

   // midpoints are only visited on sides that are not stitched
   `GFI_ASSERT_IMPL(a_odd_unmerged, clock, reset, fan_valid_ff && pos_ff[0],
      !merge_ff[pos_ff[RING_BITS-1:1]], "midpoint visited on a stitched side")
   // a new fan starts at the left side
   `GFI_ASSERT_NEXT(a_take_start, clock, reset, calc_take, fan_valid_ff && (pos_ff == '0),
      "new fan did not start at ring origin")
   // a fan is only replaced after its last triangle
   `GFI_ASSERT_IMPL(a_no_overwrite, clock, reset, calc_take, !fan_valid_ff || fan_done,
      "fan overwritten before its last triangle")

endmodule

// ----- rtl/core/geomip_fan_index_generator.sv -----
// ----------------------------------------------------------------------------
// geomip fan index generator
// triangle fan index generation with crack stitching for terrain patches
// ----------------------------------------------------------------------------
// Each fan request yields 4 to 8 triangles, one per cycle on the rsp channel
// while rsp_ch is ready; a new request is taken while the previous fan drains.
// With the sequencer idle, a request passes the calculator register, the
// sequencer fan register and the result register before the first triangle
// of its fan is valid on the rsp channel.
// Registers: grid_width at byte 0, patch_size at byte 4, clamped on write.
`timescale 1ns / 1ps

module geomip_fan_index_generator import gfi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   gfi_req_if.sink                  req_ch,
   gfi_rsp_if.source                rsp_ch,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type cfg;
   logic    calc_valid;
   logic    calc_take;
   fan_type calc_fan;

   gfi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gfi_fan_calc u_fan_calc (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg),
      .calc_valid (calc_valid),
      .calc_take  (calc_take),
      .calc_fan   (calc_fan)
   );

   gfi_tri_seq u_tri_seq (
      .clock      (clock),
      .reset      (reset),
      .calc_valid (calc_valid),
      .calc_take  (calc_take),
      .calc_fan   (calc_fan),
      .rsp        (rsp_ch)
   );

endmodule
